FILE: rtl/core/fcrt_pkg.sv
// ----------------------------------------------------------------------------
// fcrt_pkg: shared types and constants for the chunk reassembly tracker
// Verdict codes, header geometry, sentinel frame id and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package fcrt_pkg;

	localparam int CHUNK_SLOTS_DEF  = 32;
	localparam int BUFFER_BYTES_DEF = 16384;

	localparam int STRIDE_W   = 15;
	localparam int FRAME_W    = 32;
	localparam int HALF_W     = 16;
	localparam int DGRAM_W    = 11;
	localparam int OFFSET_W   = 14;
	localparam int SIZE_OUT_W = 20;

	localparam logic [STRIDE_W-1:0]   STRIDE_RESET = 15'd1190;
	localparam logic [FRAME_W-1:0]    IDLE_FRAME   = 32'hFFFF_FFFF;
	localparam logic [DGRAM_W-1:0]    HDR_BYTES    = 11'd10;
	localparam logic [SIZE_OUT_W-1:0] SIZE_MAX     = 20'hF_FFFF;

	typedef enum logic [2:0] {
		VERDICT_OK        = 3'd0,
		VERDICT_SHORT     = 3'd1,
		VERDICT_BAD_TOTAL = 3'd2,
		VERDICT_BAD_INDEX = 3'd3,
		VERDICT_BAD_LEN   = 3'd4,
		VERDICT_DUP       = 3'd5,
		VERDICT_OVERFLOW  = 3'd6
	} verdict_t;

endpackage

`default_nettype wire

FILE: rtl/core/frame_chunk_reassembly_tracker_unit.sv
// ----------------------------------------------------------------------------
// frame_chunk_reassembly_tracker_unit: per-frame chunk header tracker
// Validates chunk headers, tracks arrival of chunks of one frame in a bitmap,
// and reports buffer write offset and completed image size.
// ----------------------------------------------------------------------------
`default_nettype none

// Each request on the slave stream is one parsed chunk header; each produces
// exactly one result on the master stream. Throughput is one header per clock
// unless the master stalls: the header lands in an input register, and
// combinational check-and-update logic (an index-by-stride multiply for the
// offset, a count-by-stride multiply for the image size, an add and a compare
// against the buffer size) feeds the result register; the frame state is
// updated at the same edge. An accepted header moves on from the input
// register into the result register when it is empty or being drained;
// back-to-back requests give one result per clock while not stalled. When both
// registers are full, s_axis_tready follows m_axis_tready in the same cycle.
// Checks run in order: short datagram, bad total, bad index, bad length; then
// a new frame id restarts tracking (even if the chunk is later rejected as a
// duplicate or an overflow), then duplicate and buffer overflow. On the last
// missing chunk, tlast is raised with the image size and the tracked frame id
// falls back to the all-ones sentinel. Write chunk_stride only while idle.
module frame_chunk_reassembly_tracker_unit #(
	parameter int CHUNK_SLOTS  = fcrt_pkg::CHUNK_SLOTS_DEF,
	parameter int BUFFER_BYTES = fcrt_pkg::BUFFER_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// chunk_stride register
	input  wire logic        cfg_we,
	input  wire logic [14:0] cfg_wdata,
	// header requests
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [31:0] frame_id, [47:32] chunk_index, [63:48] chunk_total,
	// [79:64] chunk_length, [90:80] datagram_length, [95:91] zero
	input  wire logic [95:0] s_axis_tdata,
	// results
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [2:0] verdict, [16:3] write_offset, [36:17] image_size, [39:37] zero
	output logic [39:0]      m_axis_tdata,
	// frame_complete
	output logic             m_axis_tlast
);

	localparam int IDX_W  = (CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 1;
	localparam int CNT_W  = $clog2(CHUNK_SLOTS + 1);
	localparam int OFF_W  = IDX_W + fcrt_pkg::STRIDE_W;
	localparam int BUF_W  = $clog2(BUFFER_BYTES + 1);
	localparam int CMP_W  = ((OFF_W + 1) > BUF_W) ? (OFF_W + 1) : BUF_W;
	localparam int PROD_W = CNT_W + fcrt_pkg::STRIDE_W;
	localparam int SIZE_W = ((PROD_W + 1) > 21) ? (PROD_W + 1) : 21;

	// configuration
	logic [fcrt_pkg::STRIDE_W-1:0] stride_q;

	// input stage
	logic                          valid_s1;
	logic [fcrt_pkg::FRAME_W-1:0]  frame_id_s1;
	logic [fcrt_pkg::HALF_W-1:0]   chunk_index_s1;
	logic [fcrt_pkg::HALF_W-1:0]   chunk_total_s1;
	logic [fcrt_pkg::HALF_W-1:0]   chunk_length_s1;
	logic [fcrt_pkg::DGRAM_W-1:0]  datagram_length_s1;

	// frame state
	logic [fcrt_pkg::FRAME_W-1:0]  tracked_q;
	logic [CNT_W-1:0]              expected_q;
	logic [CNT_W-1:0]              arrived_q;
	logic [CHUNK_SLOTS-1:0]        marks_q;

	// result stage
	logic                          valid_s2;
	fcrt_pkg::verdict_t            verdict_s2;
	logic [fcrt_pkg::OFFSET_W-1:0] offset_s2;
	logic                          complete_s2;
	logic [fcrt_pkg::SIZE_OUT_W-1:0] size_s2;

	// check-and-update logic
	logic                          advance;
	logic                          hdr_ok;
	logic                          new_frame;
	logic [IDX_W-1:0]              idx;
	logic [CHUNK_SLOTS-1:0]        marks_eff;
	logic [CHUNK_SLOTS-1:0]        marks_set;
	logic [CNT_W-1:0]              expected_eff;
	logic [CNT_W-1:0]              arrived_eff;
	logic [CNT_W-1:0]              arrived_inc;
	logic [OFF_W-1:0]              offset;
	logic [CMP_W-1:0]              end_byte;
	logic [PROD_W-1:0]             size_prod;
	logic [SIZE_W-1:0]             size_full;
	logic                          dup;
	logic                          overflow;
	logic                          take;
	logic                          done;
	fcrt_pkg::verdict_t            verdict;

	// Advance the result register when it is empty or being drained.
	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= fcrt_pkg::STRIDE_RESET;
		end else if (cfg_we) begin
			stride_q <= cfg_wdata;
		end
	end

	// Input register: capture a header whenever the stage is free or moving.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			frame_id_s1        <= s_axis_tdata[31:0];
			chunk_index_s1     <= s_axis_tdata[47:32];
			chunk_total_s1     <= s_axis_tdata[63:48];
			chunk_length_s1    <= s_axis_tdata[79:64];
			datagram_length_s1 <= s_axis_tdata[90:80];
		end
	end

	always_comb begin
		// Header checks, in priority order; bad index also bounds idx below.
		verdict = fcrt_pkg::VERDICT_OK;
		hdr_ok  = 1'b0;
		if (datagram_length_s1 < fcrt_pkg::HDR_BYTES) begin
			verdict = fcrt_pkg::VERDICT_SHORT;
		end else if (chunk_total_s1 == '0
		             || chunk_total_s1 > fcrt_pkg::HALF_W'(CHUNK_SLOTS)) begin
			verdict = fcrt_pkg::VERDICT_BAD_TOTAL;
		end else if (chunk_index_s1 >= chunk_total_s1) begin
			verdict = fcrt_pkg::VERDICT_BAD_INDEX;
		end else if (chunk_length_s1 == '0
		             || (17'(fcrt_pkg::HDR_BYTES) + 17'(chunk_length_s1))
		                > 17'(datagram_length_s1)) begin
			verdict = fcrt_pkg::VERDICT_BAD_LEN;
		end else begin
			hdr_ok = 1'b1;
		end

		// A different frame id restarts tracking from this header's total.
		new_frame    = frame_id_s1 != tracked_q;
		marks_eff    = new_frame ? '0 : marks_q;
		expected_eff = new_frame ? CNT_W'(chunk_total_s1) : expected_q;
		arrived_eff  = new_frame ? '0 : arrived_q;

		idx       = chunk_index_s1[IDX_W-1:0];
		dup       = marks_eff[idx];
		marks_set = marks_eff | (CHUNK_SLOTS'(1) << idx);
		offset    = OFF_W'(idx) * OFF_W'(stride_q);
		end_byte  = CMP_W'(offset) + CMP_W'(chunk_length_s1);
		overflow  = end_byte > CMP_W'(BUFFER_BYTES);

		if (hdr_ok) begin
			if (dup) begin
				verdict = fcrt_pkg::VERDICT_DUP;
			end else if (overflow) begin
				verdict = fcrt_pkg::VERDICT_OVERFLOW;
			end
		end
		take = hdr_ok && !dup && !overflow;

		arrived_inc = arrived_eff + CNT_W'(1);
		done        = take && (arrived_inc == expected_eff);

		// Image size: full chunks before the last one plus the completing chunk's length.
		size_prod = PROD_W'(expected_eff - CNT_W'(1)) * PROD_W'(stride_q);
		size_full = SIZE_W'(size_prod) + SIZE_W'(chunk_length_s1);
	end

	// Frame state: update only when a header that passes the header checks moves into the result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracked_q  <= fcrt_pkg::IDLE_FRAME;
			expected_q <= '0;
			arrived_q  <= '0;
			marks_q    <= '0;
		end else if (valid_s1 && advance && hdr_ok) begin
			if (done) begin
				tracked_q <= fcrt_pkg::IDLE_FRAME;
			end else begin
				tracked_q <= frame_id_s1;
			end
			expected_q <= expected_eff;
			if (take) begin
				arrived_q <= arrived_inc;
				marks_q   <= marks_set;
			end else begin
				arrived_q <= arrived_eff;
				marks_q   <= marks_eff;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			verdict_s2  <= verdict;
			offset_s2   <= take ? offset[fcrt_pkg::OFFSET_W-1:0] : '0;
			complete_s2 <= done;
			if (!done) begin
				size_s2 <= '0;
			end else if (size_full > SIZE_W'(fcrt_pkg::SIZE_MAX)) begin
				size_s2 <= fcrt_pkg::SIZE_MAX;
			end else begin
				size_s2 <= size_full[fcrt_pkg::SIZE_OUT_W-1:0];
			end
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tlast  = complete_s2;
	assign m_axis_tdata  = {3'b000, size_s2, offset_s2, verdict_s2};

endmodule

`default_nettype wire
